@@ design/swrl_pkg.sv @@
// Shared types, constants and reset values for the sliding window rate limiter.
// Used by swrl_acc and by the top level; depends on nothing.
package swrl_pkg;

  // Size of the attempt log and the widths that follow from it.
  localparam int MAX_SLOTS = 8;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  // Field and register widths.
  localparam int TIME_W  = 32;
  localparam int ALLOW_W = 4;
  localparam int OUTC_W  = 4;
  localparam int CFG_IW  = 2;

  // Register reset values.
  localparam logic [TIME_W-1:0]  WINDOW_RST  = 32'd10000000;
  localparam logic [TIME_W-1:0]  LOCKOUT_RST = 32'd2000000;
  localparam logic [ALLOW_W-1:0] ALLOW_RST   = 4'd3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IW-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_LOCKOUT = 2'd1,
    CFG_MAX_ATT = 2'd2
  } cfg_idx_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_AGE  = 4'b0010,
    S_LOCK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Result of the shared add and compare unit.
  typedef struct packed {
    logic [TIME_W-1:0] sum;
    logic              below;
  } acc_res_t;

endpackage

@@ design/swrl_acc.sv @@
// Shared add and compare unit: ages one value by the elapsed time and tests it
// against a limit. Depends on swrl_pkg.
module swrl_acc (
  input  logic [swrl_pkg::TIME_W-1:0] age,
  input  logic [swrl_pkg::TIME_W-1:0] elapsed,
  input  logic [swrl_pkg::TIME_W-1:0] limit,
  output swrl_pkg::acc_res_t          res
);
  import swrl_pkg::*;

  logic [TIME_W:0] wide_sum;

  // The sum keeps its carry so that a wrap past 2^32 never counts as young.
  assign wide_sum  = {1'b0, age} + {1'b0, elapsed};
  assign res.sum   = wide_sum[TIME_W-1:0];
  assign res.below = (wide_sum < {1'b0, limit});

endmodule

@@ design/sliding_window_rate_limiter_lockout.sv @@
// Sliding window log rate limiter with lockout. Each input word is a tick or a
// request stamped with a 32-bit microsecond time; each gives one result word.
// Depends on swrl_pkg and swrl_acc.
//
// The stored attempt ages are walked one per cycle through a single shared add
// and compare unit; then a running lockout timer is aged and the request is
// decided. No new word is taken until the previous one is decided, so the time
// per item grows with the number of attempts held when it arrives, as the walk
// over the log memory covers each of them. A finished result waits in the
// output register while the next word is taken; the decide cycle only waits
// when the previous result is still held by out_stall. No clearing pass is
// needed after reset. Configuration is accepted at any time (ready is always
// high) but should only be written while the block is idle.
module sliding_window_rate_limiter_lockout (
  input  logic                         clk,
  input  logic                         rst,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [swrl_pkg::TIME_W-1:0]  time_us,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         allowed,
  output logic                         lockout_started,
  output logic                         lockout_active,
  output logic [swrl_pkg::OUTC_W-1:0]  held_attempts,
  // Configuration channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swrl_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [swrl_pkg::TIME_W-1:0]  cfg_data
);
  import swrl_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  // Configuration registers.
  logic [TIME_W-1:0]  window_len;
  logic [TIME_W-1:0]  lockout_us;
  logic [ALLOW_W-1:0] max_attempts;

  // Control and timing state.
  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   kept;
  logic [TIME_W-1:0]  last_time;
  logic               clock_started;
  logic               lockout_flag;
  logic [TIME_W-1:0]  lockout_age;
  logic [TIME_W-1:0]  elapsed;
  logic               cmd_req;

  // Attempt log memory and its ports.
  logic [TIME_W-1:0]  ages [MAX_SLOTS];
  logic [TIME_W-1:0]  rd_data;
  logic [SLOT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   idx_next;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [TIME_W-1:0]  wr_data;

  // Shared unit operands and result.
  logic [TIME_W-1:0]  op_age;
  logic [TIME_W-1:0]  op_limit;
  acc_res_t           acc;

  logic               in_take;
  logic               out_free;
  logic [CNT_W-1:0]   cap;
  logic               do_grant;
  logic               do_start;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign idx_next  = idx + CNT_W'(1);

  // Allowance capped at the size of the log.
  assign cap = (32'(max_attempts) >= 32'(MAX_SLOTS)) ? MAX_CNT : CNT_W'(max_attempts);

  // Decision on a request outside a lockout: grant while there is room, else lock out.
  assign do_grant = cmd_req && !lockout_flag && (count < cap);
  assign do_start = cmd_req && !lockout_flag && !(count < cap);

  // The shared unit ages a log entry during the walk and the lockout timer after it.
  assign op_age   = (state == S_LOCK) ? lockout_age : rd_data;
  assign op_limit = (state == S_LOCK) ? lockout_us : window_len;

  swrl_acc u_acc (
    .age     (op_age),
    .elapsed (elapsed),
    .limit   (op_limit),
    .res     (acc)
  );

  // Read ahead by one entry so that each walk cycle finds its age registered.
  assign rd_addr = (state == S_AGE) ? idx_next[SLOT_W-1:0] : '0;

  // Write port: surviving ages are packed down during the walk, and a granted
  // request appends a fresh age of zero.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = kept[SLOT_W-1:0];
    wr_data = acc.sum;
    if (state == S_AGE && idx != count && acc.below) begin
      wr_en = 1'b1;
    end else if (state == S_DONE && out_free && do_grant) begin
      wr_en   = 1'b1;
      wr_addr = count[SLOT_W-1:0];
      wr_data = '0;
    end
  end

  // Log memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ages[wr_addr] <= wr_data;
    end
    rd_data <= ages[rd_addr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len   <= WINDOW_RST;
      lockout_us   <= LOCKOUT_RST;
      max_attempts <= ALLOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW:  window_len   <= cfg_data;
        CFG_LOCKOUT: lockout_us   <= cfg_data;
        CFG_MAX_ATT: max_attempts <= cfg_data[ALLOW_W-1:0];
        default:     ;
      endcase
    end
  end

  // Sequencer: take a word, walk the log, age the lockout, then decide.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      idx           <= '0;
      kept          <= '0;
      last_time     <= '0;
      clock_started <= 1'b0;
      lockout_flag  <= 1'b0;
      lockout_age   <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The result word is raised by the decide cycle and dropped once taken.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            elapsed       <= clock_started ? (time_us - last_time) : '0;
            last_time     <= time_us;
            clock_started <= 1'b1;
            cmd_req       <= command;
            idx           <= '0;
            kept          <= '0;
            state         <= S_AGE;
          end
        end
        S_AGE: begin
          if (idx == count) begin
            count <= kept;
            state <= S_LOCK;
          end else begin
            if (acc.below) begin
              kept <= kept + CNT_W'(1);
            end
            idx <= idx_next;
          end
        end
        S_LOCK: begin
          if (lockout_flag) begin
            lockout_flag <= acc.below;
            lockout_age  <= acc.below ? acc.sum : '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            allowed         <= do_grant;
            lockout_started <= do_start;
            lockout_active  <= lockout_flag || do_start;
            held_attempts   <= do_grant ? OUTC_W'(count + CNT_W'(1)) : OUTC_W'(count);
            if (do_grant) begin
              count <= count + CNT_W'(1);
            end
            if (do_start) begin
              lockout_flag <= 1'b1;
              lockout_age  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The log never holds more attempts than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("attempt count exceeds log size");

  // The walk never runs past the entries that were recorded.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_AGE) |-> (idx <= count && kept <= idx))
    else $error("log walk out of range");

  // A result that starts a lockout reports it running and grants nothing.
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lockout_started) |-> (lockout_active && !allowed))
    else $error("lockout start inconsistent");

  // A grant is never given while a lockout is reported running.
  a_grant_free: assert property (@(posedge clk) disable iff (rst)
    (out_valid && allowed) |-> !lockout_active)
    else $error("request granted during lockout");
`endif

endmodule
